### rtl/core/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  localparam int unsigned MaxEntries = 4;

  // top six bits of a surrogate code unit
  localparam logic [5:0] HiSurrTag = 6'h36;  // 0xD800..0xDBFF
  localparam logic [5:0] LoSurrTag = 6'h37;  // 0xDC00..0xDFFF

  // 0x10000 + (high_bits << 10) is (high_bits + 64) << 10
  localparam logic [10:0] SuppOffset = 11'd64;

  localparam logic [20:0] OneByteMax   = 21'h00007F;
  localparam logic [20:0] TwoByteMax   = 21'h0007FF;
  localparam logic [20:0] ThreeByteMax = 21'h00FFFF;

  localparam logic [2:0] LeadTwo   = 3'b110;
  localparam logic [3:0] LeadThree = 4'b1110;
  localparam logic [4:0] LeadFour  = 5'b11110;
  localparam logic [1:0] ContTag   = 2'b10;

  // one output byte with its error flag
  typedef struct packed {
    logic       bad;
    logic [7:0] byt;
  } ent_t;

  // all results caused by one accepted item
  typedef struct packed {
    logic                      eos;
    logic [2:0]                cnt;
    ent_t [MaxEntries-1:0]     ent;
  } run_t;

  localparam ent_t ErrEnt = '{bad: 1'b1, byt: 8'h00};

  function automatic run_t enc_cp(input logic [20:0] cp);
    run_t r;
    r = '0;
    if (cp <= OneByteMax) begin
      r.cnt    = 3'd1;
      r.ent[0] = '{bad: 1'b0, byt: cp[7:0]};
    end else if (cp <= TwoByteMax) begin
      r.cnt    = 3'd2;
      r.ent[0] = '{bad: 1'b0, byt: {LeadTwo, cp[10:6]}};
      r.ent[1] = '{bad: 1'b0, byt: {ContTag, cp[5:0]}};
    end else if (cp <= ThreeByteMax) begin
      r.cnt    = 3'd3;
      r.ent[0] = '{bad: 1'b0, byt: {LeadThree, cp[15:12]}};
      r.ent[1] = '{bad: 1'b0, byt: {ContTag, cp[11:6]}};
      r.ent[2] = '{bad: 1'b0, byt: {ContTag, cp[5:0]}};
    end else begin
      r.cnt    = 3'd4;
      r.ent[0] = '{bad: 1'b0, byt: {LeadFour, cp[20:18]}};
      r.ent[1] = '{bad: 1'b0, byt: {ContTag, cp[17:12]}};
      r.ent[2] = '{bad: 1'b0, byt: {ContTag, cp[11:6]}};
      r.ent[3] = '{bad: 1'b0, byt: {ContTag, cp[5:0]}};
    end
    return r;
  endfunction

endpackage

### rtl/core/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks a held high surrogate and turns each item into
// a run descriptor of up to four result bytes.
// ----------------------------------------------------------------------------
module u2u8_front import u2u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        eos_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output run_t        q_data_o
);

  logic       pend_q, pend_d;
  logic [9:0] pend_bits_q, pend_bits_d;
  logic       accept;
  logic       is_high, is_low;
  logic [20:0] supp_cp;
  run_t       main_run, run;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_high = code_unit_i[15:10] == HiSurrTag;
  assign is_low  = code_unit_i[15:10] == LoSurrTag;
  assign supp_cp = {11'(pend_bits_q) + SuppOffset, code_unit_i[9:0]};

  always_comb begin
    main_run = '0;
    if (pend_q && is_low) begin
      main_run = enc_cp(supp_cp);
    end else if (is_high) begin
      if (eos_i) begin
        main_run.cnt    = 3'd1;
        main_run.ent[0] = ErrEnt;
      end
    end else begin
      main_run = enc_cp({5'd0, code_unit_i});
    end

    run = main_run;
    // dropped held surrogate goes out first as an error byte
    if (pend_q && !is_low) begin
      run.cnt    = main_run.cnt + 3'd1;
      run.ent[0] = ErrEnt;
      run.ent[1] = main_run.ent[0];
      run.ent[2] = main_run.ent[1];
      run.ent[3] = main_run.ent[2];
    end
    run.eos = eos_i;
  end

  assign q_push_o = accept && (run.cnt != 3'd0);
  assign q_data_o = run;

  always_comb begin
    pend_d      = pend_q;
    pend_bits_d = pend_bits_q;
    if (accept) begin
      if (is_high && !is_low && !(pend_q && is_low) && !eos_i) begin
        pend_d      = 1'b1;
        pend_bits_d = code_unit_i[9:0];
      end else begin
        pend_d      = 1'b0;
        pend_bits_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      pend_bits_q <= '0;
    end else begin
      pend_q      <= pend_d;
      pend_bits_q <= pend_bits_d;
    end
  end

  // a held surrogate followed by a low one always yields four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pend_q && is_low) |-> (q_push_o && run.cnt == 3'd4))
    else $error("surrogate pair did not produce four bytes");

  // an item ending the string always leaves something for the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eos_i) |-> q_push_o)
    else $error("end of string produced no result");

  // nothing is held after an item that ends the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eos_i) |=> !pend_q)
    else $error("surrogate held across end of string");

endmodule

### rtl/core/u2u8_fifo.sv
// ----------------------------------------------------------------------------
// u2u8_fifo
// Short register queue of run descriptors between front and back ends.
// ----------------------------------------------------------------------------
module u2u8_fifo import u2u8_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output run_t head_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  // pointers are equal when the queue is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with empty count");

endmodule

### rtl/core/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Walks the run at the queue head and sends one byte per cycle, while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module u2u8_back import u2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_bad_o,
  output logic       out_done_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_bad_q, out_done_q;
  logic       adv, emit, last_ent;
  ent_t       cur;

  assign adv      = !out_valid_q || out_ready_i;
  assign emit     = adv && !empty_i;
  assign cur      = head_i.ent[idx_q];
  assign last_ent = {1'b0, idx_q} == 3'(head_i.cnt - 3'd1);
  assign pop_o    = emit && last_ent;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = !empty_i;
    end
    if (emit) begin
      idx_d = last_ent ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur.byt;
      out_bad_q  <= cur.bad;
      out_last_q <= last_ent;
      out_done_q <= last_ent && head_i.eos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;
  assign out_done_o  = out_done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ({1'b0, idx_q} < head_i.cnt))
    else $error("byte index beyond run length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_byte_q == 8'h00))
    else $error("error item carries a nonzero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("string end not on last byte of run");

endmodule

### rtl/core/utf16_to_utf8_transcoder.sv
// an accepted item is written to the run queue, and the back end registers each of its bytes in the output stage
// throughput: one code unit per cycle while the run queue has room; the
//   output side sends one byte per cycle while the sink is ready, and an
//   item yields up to 4 bytes
// reset: asynchronous active low, empties the queue and drops a held surrogate
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Stream transcoder from UTF-16 code units to UTF-8 bytes with unpaired high
// surrogate reporting; a lone low surrogate is encoded as three bytes.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder import u2u8_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] code_unit
  input  logic        s_axis_tlast_i,  // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tlast_o,  // last_of_run
  output logic [1:0]  m_axis_tuser_o   // [0] bad_sequence, [1] string_done
);

  logic q_push, q_full, q_pop, q_empty;
  run_t q_wdata, q_head;
  logic out_bad, out_done;

  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .code_unit_i (s_axis_tdata_i),
    .eos_i       (s_axis_tlast_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  u2u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_bad_o   (out_bad),
    .out_done_o  (out_done)
  );

  assign m_axis_tuser_o = {out_done, out_bad};

endmodule
